/* rtl/afmr_pkg.sv */
`timescale 1ns / 1ps
package afmr_pkg;
    localparam int SLOTS_DEF      = 8;
    localparam int MAX_PART_DEF   = 8;
    localparam int FRAME_LEN_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PART_W  = 3;
    localparam int STAMP_W = 32;
    localparam int SAMP_W  = SAMPLE_BITS_DEF;
    localparam int ROOM_W  = 4;
    localparam int DROP_W  = 16;

    // controller -> datapath commands
    typedef struct packed {
        logic stamp_rd;   // read stamp of search slot
        logic stamp_wr;   // write stamp for frame start
        logic mix_rd;     // read mix word
        logic mix_wr;     // write mixed word
        logic emit_rd;    // read word for emission
        logic clr_wr;     // clear word of oldest slot, or of each slot at init
    } t_cmd;
endpackage

/* rtl/afmr_datapath.sv */
`timescale 1ns / 1ps
module afmr_datapath
    import afmr_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int FRAME_LEN   = FRAME_LEN_DEF,
    localparam int MAX_PART    = MAX_PART_DEF,
    localparam int SAMPLE_BITS = SAMP_W,
    localparam int SW = $clog2(SLOTS),
    localparam int PW = $clog2(MAX_PART),
    localparam int FW = $clog2(FRAME_LEN)
) (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [SW-1:0]      i_slot,
    input  logic [PW-1:0]      i_part,
    input  logic [FW-1:0]      i_pos,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [SAMP_W-1:0]  i_sample,
    output logic [STAMP_W-1:0] o_stamp_q,
    output logic [SAMP_W-1:0]  o_mix_q
);
    localparam logic [SAMPLE_BITS:0] SMAX = {1'b0, {SAMPLE_BITS{1'b1}}};
    // addressed as {slot, position} and {slot, participant}
    logic [SAMPLE_BITS-1:0] r_mix_mem [2**(SW+FW)];
    logic [STAMP_W-1:0]     r_stamp_mem [2**(SW+PW)];
    logic [SAMPLE_BITS-1:0] r_mix_q;
    logic [SAMPLE_BITS-1:0] w_b;
    logic [2*SAMPLE_BITS-1:0] w_prod;
    logic [SAMPLE_BITS+1:0] w_sum;
    logic [SAMPLE_BITS-1:0] w_mixed;
    logic [SW+FW-1:0] w_maddr;
    logic [SW+PW-1:0] w_saddr;

    assign w_maddr = {i_slot, i_pos};
    assign w_saddr = {i_slot, i_part};
    assign w_b     = i_sample[SAMPLE_BITS-1:0];
    assign w_prod  = r_mix_q * w_b;
    assign w_sum   = {2'b0, r_mix_q} + {2'b0, w_b}
                   - {2'b0, w_prod[2*SAMPLE_BITS-1:SAMPLE_BITS]};
    assign w_mixed = (w_sum > {1'b0, SMAX}) ? {SAMPLE_BITS{1'b1}} : w_sum[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_wr) begin
            r_mix_mem[w_maddr] <= w_mixed;
        end else if (i_cmd.clr_wr) begin
            r_mix_mem[w_maddr] <= '0;
        end
        if (i_cmd.mix_rd || i_cmd.emit_rd) begin
            r_mix_q <= r_mix_mem[w_maddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stamp_wr) begin
            r_stamp_mem[w_saddr] <= i_stamp;
        end else if (i_cmd.clr_wr && (32'(i_pos) < 32'(MAX_PART))) begin
            r_stamp_mem[{i_slot, i_pos[PW-1:0]}] <= '0;
        end
        if (i_cmd.stamp_rd) begin
            o_stamp_q <= r_stamp_mem[w_saddr];
        end
    end

    assign o_mix_q = SAMP_W'(r_mix_q);
endmodule

/* rtl/afmr_ctrl.sv */
`timescale 1ns / 1ps
module afmr_ctrl
    import afmr_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    localparam int MAX_PART = MAX_PART_DEF,
    localparam int SW = $clog2(SLOTS),
    localparam int PW = $clog2(MAX_PART),
    localparam int FW = $clog2(FRAME_LEN),
    localparam int CW = $clog2(SLOTS+1),
    localparam int NW = $clog2(MAX_PART+1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PART_W-1:0]  i_part,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [ROOM_W-1:0]  i_room,
    input  logic [STAMP_W-1:0] i_stamp_q,
    input  logic [SAMP_W-1:0]  i_mix_q,
    output t_cmd               o_cmd,
    output logic [SW-1:0]      o_slot,
    output logic [PW-1:0]      o_part,
    output logic [FW-1:0]      o_pos,
    output logic [STAMP_W-1:0] o_stamp,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [SAMP_W-1:0]  o_out_sample,
    output logic               o_out_last,
    output logic [DROP_W-1:0]  o_out_drops
);
    localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_SCHK = 4'd2,
                           S_MRD = 4'd3, S_MWR = 4'd4, S_ERD = 4'd5,
                           S_EOUT = 4'd6, S_CLR = 4'd7, S_INIT = 4'd8;

    logic [3:0]         r_st;
    logic [SLOTS-1:0][NW-1:0] r_fill;
    logic [SW-1:0]      r_oldest, r_cur;
    logic [CW-1:0]      r_used, r_i;
    logic [DROP_W-1:0]  r_drops;
    logic               r_dropped;
    logic [FW-1:0]      r_pos, r_epos;
    logic [PW-1:0]      r_part;
    logic [STAMP_W-1:0] r_stamp;
    logic               r_ov;
    logic [SAMP_W-1:0]  r_osamp;
    logic               r_olast;
    logic [DROP_W-1:0]  r_odrop;
    logic [SW+FW-1:0]   r_icnt;
    logic               w_last_pos, w_out_free, w_pick;
    logic [CW:0]        w_walk;
    logic [SW-1:0]      w_srch;

    assign w_last_pos = (r_pos == FW'(FRAME_LEN-1));
    assign w_out_free = !r_ov || i_out_ready;
    // oldest + walk index, wrapped round the ring
    assign w_walk     = {1'b0, CW'(r_oldest)} + {1'b0, r_i};
    assign w_srch     = (w_walk >= (CW+1)'(SLOTS)) ? SW'(w_walk - (CW+1)'(SLOTS))
                                                    : SW'(w_walk);
    // slot taken: free stamp inside the used run, or a free slot past it
    assign w_pick     = (r_i < r_used) ? (i_stamp_q == '0) : (r_used < CW'(SLOTS));
    assign o_in_ready = (r_st == S_IDLE);
    assign o_stamp    = r_stamp;

    always_comb begin
        o_cmd  = '0;
        o_slot = r_cur;
        o_part = r_part;
        o_pos  = r_pos;
        case (r_st)
            S_IDLE: begin
                o_part = i_part[PW-1:0];
                o_slot = w_srch;
                o_cmd.stamp_rd = 1'b1;
            end
            S_SRD: begin
                o_slot = w_srch;
                o_cmd.stamp_rd = 1'b1;
            end
            S_SCHK: begin
                o_slot = w_srch;
                o_cmd.stamp_wr = w_pick;
            end
            S_MRD:  o_cmd.mix_rd = 1'b1;
            S_MWR:  o_cmd.mix_wr = !r_dropped;
            S_ERD: begin
                o_pos = r_epos;
                o_cmd.emit_rd = 1'b1;
            end
            S_EOUT: o_pos = r_epos;
            S_CLR: begin
                o_slot = r_oldest;
                o_pos  = r_epos;
                o_cmd.clr_wr = 1'b1;
            end
            S_INIT: begin
                o_slot = r_icnt[SW+FW-1:FW];
                o_pos  = r_icnt[FW-1:0];
                o_cmd.clr_wr = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT; r_fill <= '0; r_oldest <= '0; r_cur <= '0;
            r_used <= '0; r_i <= '0; r_drops <= '0; r_dropped <= 1'b0;
            r_pos <= '0; r_epos <= '0; r_ov <= 1'b0; r_icnt <= '0;
        end else begin
            if (r_ov && i_out_ready && r_st != S_EOUT) r_ov <= 1'b0;
            case (r_st)
                S_INIT: begin
                    if (r_icnt == '1)
                        r_st <= S_IDLE;
                    else
                        r_icnt <= r_icnt + 1'b1;
                end
                S_IDLE: begin
                    r_i <= '0;
                    if (i_in_valid) begin
                        if (r_pos == '0) begin
                            r_part  <= i_part[PW-1:0];
                            r_stamp <= i_stamp;
                            r_cur <= '0;
                            if (32'(i_part) >= 32'(MAX_PART) || i_stamp == '0) begin
                                r_dropped <= 1'b1;
                                if (r_drops != '1) r_drops <= r_drops + 1'b1;
                                r_st <= S_MWR;
                            end else begin
                                r_dropped <= 1'b0;
                                r_st <= S_SCHK;
                            end
                        end else begin
                            r_st <= r_dropped ? S_MWR : S_MRD;
                        end
                    end
                end
                S_SRD: r_st <= S_SCHK;
                S_SCHK: begin
                    if (w_pick) begin
                        r_cur <= w_srch;
                        if (r_fill[w_srch] == '0 && r_used < CW'(SLOTS))
                            r_used <= r_used + 1'b1;
                        if (r_fill[w_srch] < NW'(MAX_PART))
                            r_fill[w_srch] <= r_fill[w_srch] + 1'b1;
                        r_st <= S_MRD;
                    end else if (r_i < r_used && i_stamp_q <= r_stamp) begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_SRD;
                    end else begin
                        // newer stamp met, or ring full
                        r_dropped <= 1'b1;
                        if (r_drops != '1) r_drops <= r_drops + 1'b1;
                        r_st <= S_MWR;
                    end
                end
                S_MRD: r_st <= S_MWR;
                S_MWR: begin
                    r_pos <= w_last_pos ? '0 : r_pos + 1'b1;
                    r_epos <= '0;
                    if (w_last_pos && !r_dropped &&
                        32'(r_fill[r_cur]) == 32'(i_room))
                        r_st <= S_ERD;
                    else
                        r_st <= S_IDLE;
                end
                S_ERD: r_st <= S_EOUT;
                S_EOUT: begin
                    if (w_out_free) begin
                        r_ov <= 1'b1;
                        r_osamp <= i_mix_q;
                        r_olast <= (r_epos == FW'(FRAME_LEN-1));
                        r_odrop <= r_drops;
                        if (r_epos == FW'(FRAME_LEN-1)) begin
                            r_epos <= '0;
                            r_st <= S_CLR;
                        end else begin
                            r_epos <= r_epos + 1'b1;
                            r_st <= S_ERD;
                        end
                    end
                end
                S_CLR: begin
                    if (r_epos == FW'(FRAME_LEN-1)) begin
                        r_fill[r_oldest] <= '0;
                        r_oldest <= (r_oldest == SW'(SLOTS-1)) ? '0 : r_oldest + 1'b1;
                        if (r_used != '0) r_used <= r_used - 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_epos <= r_epos + 1'b1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_sample = r_osamp;
    assign o_out_last   = r_olast;
    assign o_out_drops  = r_odrop;
endmodule

/* rtl/audio_frame_mix_ring_core.sv */
`timescale 1ns / 1ps
// audio_frame_mix_ring_core: ring of mixing slots for conference audio.
// Input stream (s_axis): one request per sample. tdata = participant,
// frame_stamp, sample_value from bit 0 up; participant and stamp are only
// read on a frame's first sample. Output stream (m_axis): mixed frames,
// tdata = mixed_sample, dropped_frames; tlast marks a frame's last sample.
// Config: i_cfg_we writes room_size (participants completing a slot).
// Flow: a mid-frame sample is read, mixed and written back (S_MRD, S_MWR);
// a dropped frame's sample skips the read; a frame start first checks the
// stamp of the oldest slot, then reads and checks one more stamp for each
// used slot passed by the search. A frame whose slot fills to room_size
// on its last sample is emitted word by word, each word read (S_ERD) and
// then registered (S_EOUT); afterwards the oldest slot is cleared word by
// word, and input stalls throughout emission and clear.
// A stalled receiver holds the output register and so the emission walk.
// Reset (synchronous, active low) clears control state, then both stores
// are cleared one word a cycle, with tready held low.
module audio_frame_mix_ring_core
    import afmr_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int FRAME_LEN   = FRAME_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // participant[2:0], frame_stamp[34:3], sample[50:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // mixed_sample[15:0], dropped_frames[31:16]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);
    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(MAX_PART_DEF);
    localparam int FW = $clog2(FRAME_LEN);
    logic [ROOM_W-1:0] r_room;
    t_cmd w_cmd;
    logic [SW-1:0] w_slot;
    logic [PW-1:0] w_part;
    logic [FW-1:0] w_pos;
    logic [STAMP_W-1:0] w_sq;
    logic [STAMP_W-1:0] w_st;
    logic [SAMP_W-1:0] w_mq, w_os;
    logic [DROP_W-1:0] w_od;
    logic [SAMP_W-1:0] r_samp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_room <= ROOM_W'(1);
        else if (i_cfg_we) r_room <= i_cfg_wdata;
    end
    // hold the sample of the accepted request
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_samp <= s_axis_tdata[50:35];
    end

    afmr_ctrl #(.SLOTS(SLOTS), .FRAME_LEN(FRAME_LEN)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_part(s_axis_tdata[2:0]), .i_stamp(s_axis_tdata[34:3]),
        .i_room(r_room), .i_stamp_q(w_sq), .i_mix_q(w_mq),
        .o_cmd(w_cmd), .o_slot(w_slot), .o_part(w_part), .o_pos(w_pos),
        .o_stamp(w_st),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_sample(w_os), .o_out_last(m_axis_tlast), .o_out_drops(w_od)
    );

    afmr_datapath #(.SLOTS(SLOTS), .FRAME_LEN(FRAME_LEN)) u_dp (
        .i_clk, .i_cmd(w_cmd), .i_slot(w_slot), .i_part(w_part), .i_pos(w_pos),
        .i_stamp(w_st), .i_sample(r_samp),
        .o_stamp_q(w_sq), .o_mix_q(w_mq)
    );

    assign m_axis_tdata = {w_od, w_os};
endmodule

/* rtl/afmr_checker.sv */
`timescale 1ns / 1ps
module afmr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic        m_axis_tlast,
    input logic [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken mid emission");
    a_drop_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || m_axis_tdata[31:16] == $past(m_axis_tdata[31:16]))
        else $error("drop count moved within frame");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind audio_frame_mix_ring_core afmr_checker u_chk (.*);
